// File: rtl/core/srv_pkg.sv
// ----------------------------------------------------------------------------
// srv_pkg
// shared widths, constants and cell state types of the refraction core
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;

    // refractive index, unsigned q3.12
    localparam int IDX_W     = 15;
    // dividend of the index ratio: index shifted up by 16
    localparam int DVD_W     = IDX_W + 16;
    localparam int DIV_STEPS = DVD_W;

    // eta in q4.16, saturated
    localparam int ETA_W = 20;
    // cosi with 28 fraction bits, 0 .. 2^28
    localparam int COS_W = 29;
    // cosi squared
    localparam int COS2_W = 57;
    // floor(eta^2 / 2^16)
    localparam int ETA2_W = 24;
    // 1 - cosi^2 with 28 fraction bits
    localparam int S_W = 29;
    // eta2 * s
    localparam int PROD_W = ETA2_W + S_W;
    // floor(eta * cosi / 2^22)
    localparam int CE_W = 27;
    // c = ce - sqrt(k), signed
    localparam int C_W = CE_W + 1;

    // radicand k, 44 fraction bits, padded to an even width
    localparam int K_W        = 45;
    localparam int RAD_W      = 46;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SREM_W     = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;

    localparam logic [ETA_W-1:0] ETA_MAX = {ETA_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
        logic [IDX_W-1:0] den;
    } srv_div_t;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } srv_sqrt_t;

endpackage

// File: rtl/core/srv_div_cell.sv
// ----------------------------------------------------------------------------
// srv_div_cell
// one restoring division step with its own register, plus a passenger bus
// ----------------------------------------------------------------------------
module srv_div_cell #(
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld,
    input  srv_pkg::srv_div_t     st,
    input  logic [SIDE_W-1:0]     side,
    output logic                  vld_q,
    output srv_pkg::srv_div_t     st_q,
    output logic [SIDE_W-1:0]     side_q
);
    import srv_pkg::*;

    logic [IDX_W:0]  trial;
    logic [IDX_W:0]  diff;
    logic            ge;
    srv_div_t        st_next;
    logic            vld_reg;
    srv_div_t        st_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        trial        = {st.rem, st.dvd[DVD_W-1]};
        diff         = trial - {1'b0, st.den};
        ge           = (trial >= {1'b0, st.den});
        st_next.rem  = ge ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
        st_next.dvd  = {st.dvd[DVD_W-2:0], 1'b0};
        st_next.quo  = {st.quo[DVD_W-2:0], ge};
        st_next.den  = st.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        side_reg <= side;
    end

    assign vld_q  = vld_reg;
    assign st_q   = st_reg;
    assign side_q = side_reg;

endmodule

// File: rtl/core/srv_sqrt_cell.sv
// ----------------------------------------------------------------------------
// srv_sqrt_cell
// one digit-pair square root step with its own register, plus a passenger bus
// ----------------------------------------------------------------------------
module srv_sqrt_cell #(
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld,
    input  srv_pkg::srv_sqrt_t    st,
    input  logic [SIDE_W-1:0]     side,
    output logic                  vld_q,
    output srv_pkg::srv_sqrt_t    st_q,
    output logic [SIDE_W-1:0]     side_q
);
    import srv_pkg::*;

    logic [SREM_W-1:0] rem_t;
    logic [SREM_W-1:0] trial;
    logic              ge;
    srv_sqrt_t         st_next;
    logic              vld_reg;
    srv_sqrt_t         st_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        rem_t        = {st.rem[SREM_W-3:0], st.rad[RAD_W-1:RAD_W-2]};
        trial        = {1'b0, st.root, 2'b01};
        ge           = (rem_t >= trial);
        st_next.rem  = ge ? (rem_t - trial) : rem_t;
        st_next.rad  = {st.rad[RAD_W-3:0], 2'b00};
        st_next.root = {st.root[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        side_reg <= side;
    end

    assign vld_q  = vld_reg;
    assign st_q   = st_reg;
    assign side_q = side_reg;

endmodule

// File: rtl/core/snell_refraction_vector_core.sv
// ----------------------------------------------------------------------------
// snell_refraction_vector_core
// refracts a ray direction through a surface by snell's law, in fixed point
// ----------------------------------------------------------------------------
// usage
//   a ray is taken on the rising edge where start is high and busy is low.
//   busy never rises: the core is a plain pipeline and takes a new ray every
//   cycle, one ray per clock sustained.
//   each ray gives exactly one result, shown on out_x/out_y/out_z and
//   total_internal for one cycle with done high. on its way a ray passes one
//   product stage, 31 divider cells for the index ratio, three multiply stages,
//   23 square root cells and three output stages. the cell rows make the
//   pipeline deep but do not limit the rate.
//   results are in transfer order. the receiver cannot hold results off and
//   none is needed: nothing in the core ever waits.
//   reset clears the stage valid flags only, so no stray done follows reset;
//   the data registers are not reset. there is no other state.
// ----------------------------------------------------------------------------
module snell_refraction_vector_core #(
    parameter int COMPONENT_WIDTH = srv_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COMPONENT_WIDTH-1:0] incident_x,
    input  logic signed [COMPONENT_WIDTH-1:0] incident_y,
    input  logic signed [COMPONENT_WIDTH-1:0] incident_z,
    input  logic signed [COMPONENT_WIDTH-1:0] normal_x,
    input  logic signed [COMPONENT_WIDTH-1:0] normal_y,
    input  logic signed [COMPONENT_WIDTH-1:0] normal_z,
    input  logic [srv_pkg::IDX_W-1:0]         eta_trans,
    input  logic [srv_pkg::IDX_W-1:0]         eta_inc,
    output logic                              done,
    output logic signed [COMPONENT_WIDTH-1:0] out_x,
    output logic signed [COMPONENT_WIDTH-1:0] out_y,
    output logic signed [COMPONENT_WIDTH-1:0] out_z,
    output logic                              total_internal
);
    import srv_pkg::*;

    localparam int W      = COMPONENT_WIDTH;
    localparam int NW     = W + 1;                      // negated normal
    localparam int DOT_W  = (2 * W + 2 > 30) ? 2 * W + 2 : 30;
    localparam int A_W    = ETA_W + 1 + W;              // eta * incident
    localparam int B_W    = C_W + NW;                   // c * normal
    localparam int VW     = W + 30;
    localparam int SH_W   = VW - 22;
    localparam int LATENCY = 1 + DIV_STEPS + 3 + SQRT_STEPS + 3;

    localparam int DSIDE_W = 3 * W + 3 * NW + COS_W;
    localparam int SSIDE_W = 3 * W + 3 * NW + ETA_W + CE_W + 1;

    localparam logic signed [DOT_W-1:0] ONE_DOT  = DOT_W'(64'sd268435456);
    localparam logic signed [DOT_W-1:0] MONE_DOT = -ONE_DOT;
    localparam logic [COS2_W-1:0]       ONE_Q56  = COS2_W'(1) << 56;
    localparam logic [PROD_W-1:0]       ONE_Q44  = PROD_W'(1) << 44;
    localparam logic signed [VW-1:0]    RND      = VW'(1) <<< 21;
    localparam logic signed [SH_W-1:0]  SAT_HI   = SH_W'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [SH_W-1:0]  SAT_LO   = -SAT_HI - SH_W'(1);
    localparam longint TIR_X_VAL = (W >= 16) ? 64'sd16384 : ((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [W-1:0]     TIR_X    = W'(TIR_X_VAL);

    // ------------------------------------------------------------------
    // stage a: the three products of the dot product
    // ------------------------------------------------------------------
    logic                   a_vld_reg;
    logic signed [2*W-1:0]  a_p_reg  [3];
    logic signed [W-1:0]    a_iv_reg [3];
    logic signed [W-1:0]    a_nv_reg [3];
    logic [IDX_W-1:0]       a_num_reg;
    logic [IDX_W-1:0]       a_den_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_p_reg[0]  <= incident_x * normal_x;
        a_p_reg[1]  <= incident_y * normal_y;
        a_p_reg[2]  <= incident_z * normal_z;
        a_iv_reg[0] <= incident_x;
        a_iv_reg[1] <= incident_y;
        a_iv_reg[2] <= incident_z;
        a_nv_reg[0] <= normal_x;
        a_nv_reg[1] <= normal_y;
        a_nv_reg[2] <= normal_z;
        a_num_reg   <= eta_inc;
        a_den_reg   <= eta_trans;
    end

    // ------------------------------------------------------------------
    // dot product sum, clamp, and the flip when the ray leaves the medium
    // ------------------------------------------------------------------
    logic signed [DOT_W-1:0] dot_sum;
    logic signed [DOT_W-1:0] dot_c;
    logic signed [DOT_W-1:0] cos_full;
    logic                    flip;
    logic signed [NW-1:0]    nv_f [3];
    logic [IDX_W-1:0]        num_f;
    logic [IDX_W-1:0]        den_f;

    logic              div_vld  [DIV_STEPS+1];
    srv_div_t          div_st   [DIV_STEPS+1];
    logic [DSIDE_W-1:0] div_side [DIV_STEPS+1];

    always_comb
    begin
        dot_sum = DOT_W'(a_p_reg[0]) + DOT_W'(a_p_reg[1]) + DOT_W'(a_p_reg[2]);
        if (dot_sum > ONE_DOT)
        begin
            dot_c = ONE_DOT;
        end
        else if (dot_sum < MONE_DOT)
        begin
            dot_c = MONE_DOT;
        end
        else
        begin
            dot_c = dot_sum;
        end
        // cosi is minus the dot product; a positive dot means an exiting ray
        flip     = (dot_c > 0);
        cos_full = flip ? dot_c : -dot_c;
        num_f    = flip ? a_den_reg : a_num_reg;
        den_f    = flip ? a_num_reg : a_den_reg;
        for (int j = 0; j < 3; j++)
        begin
            nv_f[j] = flip ? -NW'(a_nv_reg[j]) : NW'(a_nv_reg[j]);
        end
    end

    assign div_vld[0]     = a_vld_reg;
    assign div_st[0].rem  = '0;
    assign div_st[0].dvd  = {num_f, 16'b0};
    assign div_st[0].quo  = '0;
    assign div_st[0].den  = den_f;
    assign div_side[0]    = {a_iv_reg[0], a_iv_reg[1], a_iv_reg[2],
                             nv_f[0], nv_f[1], nv_f[2], cos_full[COS_W-1:0]};

    // ------------------------------------------------------------------
    // divider row: one quotient bit of eta per cell
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        srv_div_cell #(
            .SIDE_W (DSIDE_W)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .vld    (div_vld[i]),
            .st     (div_st[i]),
            .side   (div_side[i]),
            .vld_q  (div_vld[i+1]),
            .st_q   (div_st[i+1]),
            .side_q (div_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage c: saturate eta, square cosi
    // ------------------------------------------------------------------
    logic signed [W-1:0]  dx_iv [3];
    logic signed [NW-1:0] dx_nv [3];
    logic [COS_W-1:0]     dx_cos;
    logic [DVD_W-1:0]     dx_quo;

    assign dx_quo = div_st[DIV_STEPS].quo;
    assign {dx_iv[0], dx_iv[1], dx_iv[2], dx_nv[0], dx_nv[1], dx_nv[2], dx_cos}
        = div_side[DIV_STEPS];

    logic                 c_vld_reg;
    logic signed [W-1:0]  c_iv_reg [3];
    logic signed [NW-1:0] c_nv_reg [3];
    logic [COS_W-1:0]     c_cos_reg;
    logic [ETA_W-1:0]     c_eta_reg;
    logic [COS2_W-1:0]    c_cos2_reg;
    logic [2*COS_W-1:0]   cos2_full;

    assign cos2_full = dx_cos * dx_cos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= div_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        c_iv_reg   <= dx_iv;
        c_nv_reg   <= dx_nv;
        c_cos_reg  <= dx_cos;
        c_eta_reg  <= (|dx_quo[DVD_W-1:ETA_W]) ? ETA_MAX : dx_quo[ETA_W-1:0];
        c_cos2_reg <= cos2_full[COS2_W-1:0];
    end

    // ------------------------------------------------------------------
    // stage d: eta squared, one minus cos squared, eta times cosi
    // ------------------------------------------------------------------
    logic                 d_vld_reg;
    logic signed [W-1:0]  d_iv_reg [3];
    logic signed [NW-1:0] d_nv_reg [3];
    logic [ETA_W-1:0]     d_eta_reg;
    logic [ETA2_W-1:0]    d_eta2_reg;
    logic [S_W-1:0]       d_s_reg;
    logic [CE_W-1:0]      d_ce_reg;
    logic [2*ETA_W-1:0]   eta_sq;
    logic [COS2_W-1:0]    one_m_cos2;
    logic [COS_W+ETA_W-1:0] ce_full;

    always_comb
    begin
        eta_sq     = c_eta_reg * c_eta_reg;
        one_m_cos2 = ONE_Q56 - c_cos2_reg;
        ce_full    = c_cos_reg * c_eta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_iv_reg   <= c_iv_reg;
        d_nv_reg   <= c_nv_reg;
        d_eta_reg  <= c_eta_reg;
        d_eta2_reg <= eta_sq[2*ETA_W-1:16];
        d_s_reg    <= one_m_cos2[COS2_W-1:28];
        d_ce_reg   <= ce_full[COS_W+ETA_W-1:22];
    end

    // ------------------------------------------------------------------
    // stage e: eta^2 (1 - cos^2)
    // ------------------------------------------------------------------
    logic                 e_vld_reg;
    logic signed [W-1:0]  e_iv_reg [3];
    logic signed [NW-1:0] e_nv_reg [3];
    logic [ETA_W-1:0]     e_eta_reg;
    logic [CE_W-1:0]      e_ce_reg;
    logic [PROD_W-1:0]    e_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else
        begin
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_iv_reg   <= d_iv_reg;
        e_nv_reg   <= d_nv_reg;
        e_eta_reg  <= d_eta_reg;
        e_ce_reg   <= d_ce_reg;
        e_prod_reg <= d_eta2_reg * d_s_reg;
    end

    // k = 1 - eta^2 (1 - cos^2); total internal reflection when negative
    logic              tir_e;
    logic [PROD_W-1:0] k_full;

    assign tir_e  = (e_prod_reg > ONE_Q44);
    assign k_full = ONE_Q44 - e_prod_reg;

    logic               sq_vld  [SQRT_STEPS+1];
    srv_sqrt_t          sq_st   [SQRT_STEPS+1];
    logic [SSIDE_W-1:0] sq_side [SQRT_STEPS+1];

    assign sq_vld[0]     = e_vld_reg;
    assign sq_st[0].rad  = tir_e ? '0 : {1'b0, k_full[K_W-1:0]};
    assign sq_st[0].rem  = '0;
    assign sq_st[0].root = '0;
    assign sq_side[0]    = {e_iv_reg[0], e_iv_reg[1], e_iv_reg[2],
                            e_nv_reg[0], e_nv_reg[1], e_nv_reg[2],
                            e_eta_reg, e_ce_reg, tir_e};

    // ------------------------------------------------------------------
    // square root row: one root bit of sqrt(k) per cell
    // ------------------------------------------------------------------
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        srv_sqrt_cell #(
            .SIDE_W (SSIDE_W)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .vld    (sq_vld[i]),
            .st     (sq_st[i]),
            .side   (sq_side[i]),
            .vld_q  (sq_vld[i+1]),
            .st_q   (sq_st[i+1]),
            .side_q (sq_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // stage f: c = eta*cosi - sqrt(k)
    // ------------------------------------------------------------------
    logic signed [W-1:0]  sx_iv [3];
    logic signed [NW-1:0] sx_nv [3];
    logic [ETA_W-1:0]     sx_eta;
    logic [CE_W-1:0]      sx_ce;
    logic                 sx_tir;

    assign {sx_iv[0], sx_iv[1], sx_iv[2], sx_nv[0], sx_nv[1], sx_nv[2],
            sx_eta, sx_ce, sx_tir} = sq_side[SQRT_STEPS];

    logic                 f_vld_reg;
    logic signed [W-1:0]  f_iv_reg [3];
    logic signed [NW-1:0] f_nv_reg [3];
    logic [ETA_W-1:0]     f_eta_reg;
    logic signed [C_W-1:0] f_c_reg;
    logic                 f_tir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= sq_vld[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        f_iv_reg  <= sx_iv;
        f_nv_reg  <= sx_nv;
        f_eta_reg <= sx_eta;
        f_c_reg   <= $signed({1'b0, sx_ce}) - $signed(C_W'(sq_st[SQRT_STEPS].root));
        f_tir_reg <= sx_tir;
    end

    // ------------------------------------------------------------------
    // stage g: eta*I and c*N per component
    // ------------------------------------------------------------------
    logic                  g_vld_reg;
    logic signed [A_W-1:0] g_a_reg [3];
    logic signed [B_W-1:0] g_b_reg [3];
    logic                  g_tir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_vld_reg <= 1'b0;
        end
        else
        begin
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            g_a_reg[j] <= $signed({1'b0, f_eta_reg}) * f_iv_reg[j];
            g_b_reg[j] <= f_c_reg * f_nv_reg[j];
        end
        g_tir_reg <= f_tir_reg;
    end

    // ------------------------------------------------------------------
    // stage h: sum, round to nearest with ties up, saturate
    // ------------------------------------------------------------------
    logic signed [VW-1:0]   v_sum [3];
    logic signed [SH_W-1:0] v_sh  [3];
    logic signed [W-1:0]    v_sat [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            v_sum[j] = (VW'(g_a_reg[j]) <<< 6) + VW'(g_b_reg[j]) + RND;
            v_sh[j]  = SH_W'(v_sum[j] >>> 22);
            if (v_sh[j] > SAT_HI)
            begin
                v_sat[j] = SAT_HI[W-1:0];
            end
            else if (v_sh[j] < SAT_LO)
            begin
                v_sat[j] = SAT_LO[W-1:0];
            end
            else
            begin
                v_sat[j] = v_sh[j][W-1:0];
            end
        end
    end

    logic                done_reg;
    logic signed [W-1:0] out_x_reg;
    logic signed [W-1:0] out_y_reg;
    logic signed [W-1:0] out_z_reg;
    logic                tir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= g_vld_reg;
        end
    end

    // on total internal reflection the direction is forced to the unit x axis
    always_ff @(posedge clk)
    begin
        out_x_reg <= g_tir_reg ? TIR_X : v_sat[0];
        out_y_reg <= g_tir_reg ? '0 : v_sat[1];
        out_z_reg <= g_tir_reg ? '0 : v_sat[2];
        tir_reg   <= g_tir_reg;
    end

    assign done           = done_reg;
    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign out_z          = out_z_reg;
    assign total_internal = tir_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_done_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching transfer");

    a_tir_vector : assert property (@(posedge clk) disable iff (!rst_n)
        (done && total_internal) |-> (out_x == TIR_X && out_y == '0 && out_z == '0))
        else $error("total internal reflection without the unit x vector");

    a_tir_root_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld[SQRT_STEPS] && sx_tir) |-> (sq_st[SQRT_STEPS].root == '0))
        else $error("square root row carried a radicand on total internal reflection");

    a_eta_divzero : assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld[DIV_STEPS] && div_st[DIV_STEPS].den == '0)
            |=> (c_eta_reg == ETA_MAX))
        else $error("zero index divisor did not saturate eta");

endmodule
